FILE: hw/rtl/ppt_pkg.sv
// shared types, constants and witness tables of the proth test core
package ppt_pkg;

    localparam int K_W       = 63;
    localparam int EXP_W     = 6;
    localparam int VERDICT_W = 2;
    localparam int WIT_W     = 5;
    localparam int NUM_BASES = 10;

    localparam logic [EXP_W-1:0] EXP_RESET = 6'd52;

    localparam logic [VERDICT_W-1:0] VERDICT_RANGE  = 2'd0;
    localparam logic [VERDICT_W-1:0] VERDICT_NO_WIT = 2'd1;
    localparam logic [VERDICT_W-1:0] VERDICT_REJECT = 2'd2;
    localparam logic [VERDICT_W-1:0] VERDICT_PRIME  = 2'd3;

    typedef logic [WIT_W-1:0] t_res;
    typedef t_res t_res_vec [NUM_BASES];

    localparam t_res PRIMES [NUM_BASES] = '{
        5'd2, 5'd3, 5'd5, 5'd7, 5'd11, 5'd13, 5'd17, 5'd19, 5'd23, 5'd29
    };

    // bit r set when r is a nonzero quadratic residue of the odd prime; the entry for 2 is zero
    localparam logic [31:0] QR_MASK [NUM_BASES] = '{
        32'h0000_0000, 32'h0000_0002, 32'h0000_0012, 32'h0000_0016,
        32'h0000_023A, 32'h0000_161A, 32'h0001_A316, 32'h0003_0AF2,
        32'h0005_335E, 32'h13D1_22F2
    };

endpackage

FILE: hw/rtl/ppt_ifs.sv
// item channel interfaces of the proth test core
interface ppt_in_if;
    import ppt_pkg::*;
    logic           valid;
    logic           ready;
    logic [K_W-1:0] k_value;
    modport source (output valid, output k_value, input ready);
    modport sink   (input valid, input k_value, output ready);
endinterface

interface ppt_out_if;
    import ppt_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [VERDICT_W-1:0] verdict;
    logic [WIT_W-1:0]     witness;
    modport source (output valid, output verdict, output witness, input ready);
    modport sink   (input valid, input verdict, input witness, output ready);
endinterface

FILE: hw/rtl/proth_primality_test_core.sv
// proth test core: top level sequencer around the shared modular multiplier
//
// channel   dir  handshake      payload
// i_in      in   valid/ready    k_value[62:0]
// o_out     out  valid/ready    verdict[1:0], witness[4:0]
// i_cfg     in   write enable   exponent[5:0]
//
// an item with k out of range goes straight to the done state, and its result is registered
// there once the output register is free; otherwise NW residue steps, a jacobi check, then
// NW-1 squarings and one base multiply per set bit of (N-1)/2, and a final compare; each
// product takes NW steps, one more per set bit of its second operand
// ready only while idle; a finished item waits in the output register and the
// next item may start meanwhile; synchronous reset clears all control state
module proth_primality_test_core #(
    parameter int MAX_EXPONENT = 63
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [ppt_pkg::EXP_W-1:0] i_cfg_wdata,
    ppt_in_if.sink                    i_in,
    ppt_out_if.source                 o_out
);
    import ppt_pkg::*;

    localparam int NW = 2 * MAX_EXPONENT + 1;
    localparam int IW = $clog2(NW);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RES  = 3'd1;
    localparam logic [2:0] S_JAC  = 3'd2;
    localparam logic [2:0] S_SQ   = 3'd3;
    localparam logic [2:0] S_MB   = 3'd4;
    localparam logic [2:0] S_CMP  = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    logic [2:0]           r_state;
    logic [EXP_W-1:0]     r_exp;
    logic [NW-1:0]        r_num;
    logic [NW-1:0]        r_half;
    logic [NW-1:0]        r_r;
    logic [WIT_W-1:0]     r_base;
    logic [IW-1:0]        r_idx;
    logic [VERDICT_W-1:0] r_pv;
    logic [WIT_W-1:0]     r_pw;
    logic [VERDICT_W-1:0] r_verdict;
    logic [WIT_W-1:0]     r_witness;
    logic                 r_ovalid;
    logic                 r_mm_start;
    logic                 r_rs_start;

    logic [EXP_W-1:0] n_eff;
    logic             k_bad;
    logic             accept;
    logic             mm_done;
    logic [NW-1:0]    mm_res;
    logic [NW-1:0]    mm_b;
    logic             rs_done;
    t_res_vec         rs_res;
    logic             jac_found;
    logic [WIT_W-1:0] jac_base;
    logic             bit_set;

    always_comb begin
        if (r_exp == '0) begin
            n_eff = EXP_W'(1);
        end else if (r_exp > EXP_W'(MAX_EXPONENT)) begin
            n_eff = EXP_W'(MAX_EXPONENT);
        end else begin
            n_eff = r_exp;
        end
    end

    assign k_bad  = (i_in.k_value == '0) || ((i_in.k_value >> n_eff) != '0);
    assign accept = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_IDLE);

    // first witness whose jacobi symbol against the candidate is minus one
    always_comb begin
        logic flip;
        logic neg;
        jac_found = 1'b0;
        jac_base  = '0;
        for (int i = NUM_BASES - 1; i >= 0; i--) begin
            flip = 1'b0;
            if (i == 0) begin
                neg = (r_num[2:0] == 3'd3) || (r_num[2:0] == 3'd5);
            end else begin
                flip = (PRIMES[i][1:0] == 2'b11) && (r_num[1:0] == 2'b11);
                neg  = (rs_res[i] != '0) && (QR_MASK[i][rs_res[i]] == flip);
            end
            if (neg) begin
                jac_found = 1'b1;
                jac_base  = PRIMES[i];
            end
        end
    end

    assign mm_b    = (r_state == S_MB) ? NW'(r_base) : r_r;
    assign bit_set = r_half[r_idx];

    ppt_resid #(.W(NW)) u_resid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_rs_start),
        .i_num   (r_num),
        .o_done  (rs_done),
        .o_res   (rs_res)
    );

    ppt_modmul #(.W(NW)) u_modmul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_mm_start),
        .i_a     (r_r),
        .i_b     (mm_b),
        .i_m     (r_num),
        .o_done  (mm_done),
        .o_res   (mm_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_exp      <= EXP_RESET;
            r_ovalid   <= 1'b0;
            r_mm_start <= 1'b0;
            r_rs_start <= 1'b0;
        end else begin
            r_mm_start <= 1'b0;
            r_rs_start <= 1'b0;
            if (i_cfg_we) begin
                r_exp <= i_cfg_wdata;
            end
            if (r_ovalid && o_out.ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_num  <= (NW'(i_in.k_value) << n_eff) | NW'(1);
                        r_half <= NW'(i_in.k_value) << (n_eff - EXP_W'(1));
                        if (k_bad) begin
                            r_pv    <= VERDICT_RANGE;
                            r_pw    <= '0;
                            r_state <= S_DONE;
                        end else begin
                            r_rs_start <= 1'b1;
                            r_state    <= S_RES;
                        end
                    end
                end
                S_RES: begin
                    if (rs_done) begin
                        r_state <= S_JAC;
                    end
                end
                S_JAC: begin
                    if (jac_found) begin
                        r_base     <= jac_base;
                        r_r        <= NW'(1);
                        r_idx      <= IW'(NW - 2);
                        r_mm_start <= 1'b1;
                        r_state    <= S_SQ;
                    end else begin
                        r_pv    <= VERDICT_NO_WIT;
                        r_pw    <= '0;
                        r_state <= S_DONE;
                    end
                end
                S_SQ, S_MB: begin
                    if (mm_done) begin
                        r_r <= mm_res;
                        if (r_state == S_SQ && bit_set) begin
                            r_mm_start <= 1'b1;
                            r_state    <= S_MB;
                        end else if (r_idx == '0) begin
                            r_state <= S_CMP;
                        end else begin
                            r_idx      <= r_idx - IW'(1);
                            r_mm_start <= 1'b1;
                            r_state    <= S_SQ;
                        end
                    end
                end
                S_CMP: begin
                    if (r_r == {r_num[NW-1:1], 1'b0}) begin
                        r_pv <= VERDICT_PRIME;
                        r_pw <= r_base;
                    end else begin
                        r_pv <= VERDICT_REJECT;
                        r_pw <= '0;
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_ovalid || o_out.ready) begin
                        r_verdict <= r_pv;
                        r_witness <= r_pw;
                        r_ovalid  <= 1'b1;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out.valid   = r_ovalid;
    assign o_out.verdict = r_verdict;
    assign o_out.witness = r_witness;

    a_mm_start_in_ladder: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mm_start |-> (r_state == S_SQ || r_state == S_MB))
        else $error("multiplier started outside the ladder");

    a_prime_has_witness: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && r_verdict == VERDICT_PRIME |-> r_witness != '0)
        else $error("accepted item without witness");

    a_other_no_witness: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && r_verdict != VERDICT_PRIME |-> r_witness == '0)
        else $error("witness on an item that is not accepted");

endmodule

FILE: hw/rtl/ppt_resid.sv
// bit-serial residues of the candidate modulo each small prime
module ppt_resid #(
    parameter int W = 127
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [W-1:0]     i_num,
    output logic             o_done,
    output ppt_pkg::t_res_vec o_res
);
    import ppt_pkg::*;

    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  r_num;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    t_res_vec      r_res;
    t_res_vec      n_res;

    always_comb begin
        logic [WIT_W:0] t;
        for (int i = 0; i < NUM_BASES; i++) begin
            t = {r_res[i], r_num[W-1]};
            if (t >= {1'b0, PRIMES[i]}) begin
                t = t - {1'b0, PRIMES[i]};
            end
            n_res[i] = t[WIT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_num  <= i_num;
                r_cnt  <= CW'(W);
                for (int i = 0; i < NUM_BASES; i++) begin
                    r_res[i] <= '0;
                end
            end else if (r_busy) begin
                r_res <= n_res;
                r_num <= r_num << 1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - CW'(1);
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("residue done without a run");

endmodule

FILE: hw/rtl/ppt_modmul.sv
// shared modular multiplier, one double or add step per cycle
module ppt_modmul #(
    parameter int W = 127
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_a,
    input  logic [W-1:0] i_b,
    input  logic [W-1:0] i_m,
    output logic         o_done,
    output logic [W-1:0] o_res
);

    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  r_acc;
    logic [W-1:0]  r_a;
    logic [W-1:0]  r_b;
    logic [W-1:0]  r_m;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_phase;
    logic          r_done;
    logic [W:0]    n_step;

    always_comb begin
        if (r_phase) begin
            n_step = {1'b0, r_acc} + {1'b0, r_a};
        end else begin
            n_step = {r_acc, 1'b0};
        end
        if (n_step >= {1'b0, r_m}) begin
            n_step = n_step - {1'b0, r_m};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_phase <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_phase <= 1'b0;
                r_acc   <= '0;
                r_a     <= i_a;
                r_b     <= i_b;
                r_m     <= i_m;
                r_cnt   <= CW'(W);
            end else if (r_busy) begin
                r_acc <= n_step[W-1:0];
                if (!r_phase && r_b[W-1]) begin
                    r_phase <= 1'b1;
                end else begin
                    r_phase <= 1'b0;
                    r_b     <= r_b << 1;
                    if (r_cnt == CW'(1)) begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                    end else begin
                        r_cnt <= r_cnt - CW'(1);
                    end
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_res  = r_acc;

    a_acc_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && !i_start |-> r_acc < r_m)
        else $error("accumulator not reduced");

endmodule

FILE: verif/ppt_ifs_tb_note.sv
// testbench-side type for one expected verdict of the proth test core
package ppt_tb_pkg;
    import ppt_pkg::*;

    typedef struct packed {
        logic [VERDICT_W-1:0] verdict;
        logic [WIT_W-1:0]     witness;
    } t_verdict_item;

endpackage

FILE: verif/proth_primality_test_core_test.sv
// testbench of the proth test core: directed and random candidates checked against a predictor
module proth_primality_test_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ppt_pkg::*;
    import ppt_tb_pkg::*;

    localparam longint CYCLE_LIMIT = 64'd60_000_000;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [EXP_W-1:0] i_cfg_wdata;

    ppt_in_if  in_if ();
    ppt_out_if out_if ();

    proth_primality_test_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_if),
        .o_out       (out_if)
    );

    logic [EXP_W-1:0] cur_exponent;
    t_verdict_item    verdict_q[$];
    int               mismatches;
    int               send_idle_pct;
    int               recv_stall_pct;
    int               hold_left;
    longint           cycle_cnt;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // prime p, returns (p/N) as -1, 0 or 1
    function automatic int jacobi_of(int p, logic [127:0] num);
        int r;
        int acc;
        int j;
        if (p == 2) begin
            r = int'(num % 128'd8);
            return (r == 1 || r == 7) ? 1 : -1;
        end
        r = int'(num % p);
        if (r == 0) return 0;
        acc = 1;
        for (int e = 0; e < (p - 1) / 2; e++) acc = (acc * r) % p;
        j = (acc == 1) ? 1 : -1;
        if ((p % 4) == 3 && (num % 128'd4) == 128'd3) j = -j;
        return j;
    endfunction

    function automatic t_verdict_item proth_verdict(logic [K_W-1:0] k, logic [EXP_W-1:0] expo);
        t_verdict_item res;
        int            n;
        logic [127:0]  num;
        logic [127:0]  half;
        logic [255:0]  acc;
        logic [255:0]  base;
        int            p;
        n = (expo == 0) ? 1 : int'(expo);
        res.verdict = VERDICT_NO_WIT;
        res.witness = '0;
        if (k == '0 || {1'b0, k} >= (64'd1 << n)) begin
            res.verdict = VERDICT_RANGE;
            return res;
        end
        num  = ({65'd0, k} << n) | 128'd1;
        half = {65'd0, k} << (n - 1);
        for (int i = 0; i < NUM_BASES; i++) begin
            p = int'(PRIMES[i]);
            if (jacobi_of(p, num) == -1) begin
                base = {128'd0, 128'(p)} % {128'd0, num};
                acc  = 256'd1;
                for (int b = 127; b >= 0; b--) begin
                    acc = (acc * acc) % {128'd0, num};
                    if (half[b]) acc = (acc * base) % {128'd0, num};
                end
                if (acc[127:0] == num - 128'd1) begin
                    res.verdict = VERDICT_PRIME;
                    res.witness = PRIMES[i];
                end else begin
                    res.verdict = VERDICT_REJECT;
                end
                break;
            end
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("proth_primality_test_core_test: FAIL");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (hold_left > 0) hold_left <= hold_left - 1;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_verdict_item want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (verdict_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected item: verdict %0d witness %0d",
                             out_if.verdict, out_if.witness);
            end else begin
                want = verdict_q.pop_front();
                if (want.verdict !== out_if.verdict || want.witness !== out_if.witness) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected verdict %0d witness %0d, got %0d %0d",
                                 want.verdict, want.witness, out_if.verdict, out_if.witness);
                end
            end
        end
    end

    task automatic send_k(logic [K_W-1:0] k);
        if ($urandom_range(99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        end
        in_if.valid   <= 1'b1;
        in_if.k_value <= k;
        do @(posedge i_clk); while (!in_if.ready);
        verdict_q.insert(verdict_q.size(), proth_verdict(k, cur_exponent));
    endtask

    task automatic set_exponent(logic [EXP_W-1:0] expo);
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (verdict_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= expo;
        @(posedge i_clk);
        i_cfg_we     <= 1'b0;
        cur_exponent = expo;
    endtask

    function automatic logic [K_W-1:0] rand_k63();
        return K_W'({$urandom, $urandom});
    endfunction

    task automatic test_directed();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_k('0);
        send_k(63'd1);
        send_k(63'd3);
        send_k((63'd1 << 52) - 63'd1);
        send_k(63'd1 << 52);
        send_k({K_W{1'b1}});
        set_exponent(6'd1);
        send_k(63'd1);
        send_k(63'd2);
        set_exponent(6'd2);
        send_k(63'd3);
        send_k(63'd1);
        set_exponent(6'd4);
        // square candidate: no nonresidue witness
        send_k(63'd3);
        send_k(63'd1);
        send_k(63'd15);
        set_exponent(6'd0);
        send_k(63'd1);
        send_k(63'd2);
        set_exponent(6'd63);
        send_k({K_W{1'b1}});
        send_k(63'h2AAA_AAAA_AAAA_AAAA);
        send_k(63'h5555_5555_5555_5555);
        send_k(63'd1);
    endtask

    task automatic test_random_phase(int idle_pct, int stall_pct, int items, bit pressure);
        int               n;
        int               kbits;
        logic [K_W-1:0]   k;
        logic [EXP_W-1:0] expo;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < items; i++) begin
            if (i % 8 == 0) begin
                case ($urandom_range(9))
                    0:       expo = 6'd0;
                    1:       expo = 6'd63;
                    2:       expo = EXP_W'($urandom_range(20, 62));
                    default: expo = EXP_W'($urandom_range(1, 10));
                endcase
                set_exponent(expo);
                if (pressure && i == 0) hold_left = 200000;
            end
            n = (cur_exponent == 0) ? 1 : int'(cur_exponent);
            case ($urandom_range(9))
                0: k = rand_k63();
                1: k = '0;
                default: begin
                    kbits = (n < 12) ? n : $urandom_range(1, 12);
                    k = rand_k63() & ((63'd1 << kbits) - 63'd1);
                    if (k == '0) k = 63'd1;
                end
            endcase
            send_k(k);
        end
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_wdata    = '0;
        in_if.valid    = 1'b0;
        in_if.k_value  = '0;
        cur_exponent   = EXP_RESET;
        mismatches     = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_left      = 0;
        cycle_cnt      = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random_phase(0, 0, 24, 1'b1);
        test_random_phase(82, 0, 24, 1'b0);
        test_random_phase(0, 82, 24, 1'b0);
        test_random_phase(6, 6, 24, 1'b0);

        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (verdict_q.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("proth_primality_test_core_test: PASS");
        end else begin
            $display("proth_primality_test_core_test: FAIL");
        end
        $finish;
    end

endmodule
